// ===== sv/nrzi_tape_block_check_assert.svh =====
// assertion macros for the nrzi tape block check
// used by the top level; expects signals named clock and reset in scope
`ifndef NRZI_TAPE_BLOCK_CHECK_ASSERT_SVH
`define NRZI_TAPE_BLOCK_CHECK_ASSERT_SVH

// same-cycle implication
`define NTBC_ASSERT_NOW(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define NTBC_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/ntbc_pkg.sv =====
// shared types, constants and fold function for the nrzi tape block check
// no dependencies
package ntbc_pkg;

   localparam int MAX_FRAMES = 32768;
   localparam int CNT_W      = $clog2(MAX_FRAMES + 1);
   localparam int FRAME_W    = 9;
   localparam int OUT_CNT_W  = 16;
   localparam int CSR_IDX_W  = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_NINE_TRACK = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_PARITY     = CSR_IDX_W'(1);

   localparam logic [1:0] KIND_NOISE    = 2'd0;
   localparam logic [1:0] KIND_TAPEMARK = 2'd1;
   localparam logic [1:0] KIND_DATA     = 2'd2;

   localparam logic [FRAME_W-1:0] MASK7      = 9'h07f;
   localparam logic [FRAME_W-1:0] TM9_MARK   = 9'h026;
   localparam logic [FRAME_W-1:0] TM7_MARK   = 9'h01e;
   localparam logic [FRAME_W-1:0] CRC_POLY   = 9'h0f0;
   localparam logic [FRAME_W-1:0] CRC_XOROUT = 9'h1af;

   typedef struct packed {
      logic [FRAME_W-1:0]   crc;
      logic [FRAME_W-1:0]   lrc;
      logic [OUT_CNT_W-1:0] perr;
   } fold_type;

   typedef struct packed {
      logic [1:0]           block_kind;
      logic [OUT_CNT_W-1:0] data_frames;
      logic [OUT_CNT_W-1:0] parity_errors;
      logic                 crc_bad;
      logic                 lrc_bad;
      logic [OUT_CNT_W-1:0] error_total;
      logic [FRAME_W-1:0]   crc_read;
      logic [FRAME_W-1:0]   lrc_read;
   } result_type;

   // one data frame into parity count, lrc and rotating crc
   function automatic fold_type fold_frame(fold_type cur, logic [FRAME_W-1:0] d,
                                           logic pexp);
      fold_type           nxt;
      logic [FRAME_W-1:0] c;
      c = cur.crc ^ d;
      if (c[1]) begin
         c = c ^ CRC_POLY;
      end
      nxt.crc = {c[0], c[FRAME_W-1:1]};
      nxt.lrc = cur.lrc ^ d;
      nxt.perr = cur.perr;
      if (((^d) != pexp) && (cur.perr != {OUT_CNT_W{1'b1}})) begin
         nxt.perr = cur.perr + OUT_CNT_W'(1);
      end
      return nxt;
   endfunction

endpackage

// ===== sv/ntbc_req_if.sv =====
// input channel: one tape frame per item with end-of-block flag
// depends on ntbc_pkg
interface ntbc_req_if
   import ntbc_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [FRAME_W-1:0] frame;
   logic               last_frame;

   modport source (output valid, frame, last_frame, input ready);
   modport sink (input valid, frame, last_frame, output ready);
endinterface

// ===== sv/ntbc_rsp_if.sv =====
// result channel: one block report per item
// depends on ntbc_pkg
interface ntbc_rsp_if
   import ntbc_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [1:0]           block_kind;
   logic [OUT_CNT_W-1:0] data_frames;
   logic [OUT_CNT_W-1:0] parity_errors;
   logic                 crc_bad;
   logic                 lrc_bad;
   logic [OUT_CNT_W-1:0] error_total;
   logic [FRAME_W-1:0]   crc_read;
   logic [FRAME_W-1:0]   lrc_read;

   modport source (output valid, block_kind, data_frames, parity_errors, crc_bad,
                   lrc_bad, error_total, crc_read, lrc_read, input ready);
   modport sink (input valid, block_kind, data_frames, parity_errors, crc_bad,
                 lrc_bad, error_total, crc_read, lrc_read, output ready);
endinterface

// ===== sv/ntbc_csr_if.sv =====
// configuration write channel: register index and data
// depends on ntbc_pkg
interface ntbc_csr_if
   import ntbc_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic                 data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/ntbc_core.sv =====
// per-block state and combinational frame fold with end-of-block report
// depends on ntbc_pkg
module ntbc_core
   import ntbc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  logic [FRAME_W-1:0] frame,
   input  logic               last_frame,
   input  logic               nine_track,
   input  logic               parity_exp,
   output result_type         result
);

   logic [CNT_W-1:0]   count_ff, count_in;
   logic [FRAME_W-1:0] first_ff [3];
   logic [FRAME_W-1:0] first_in [3];
   logic [FRAME_W-1:0] held0_ff, held0_in, held1_ff, held1_in;
   fold_type           acc_ff, acc_in;

   logic [CNT_W-1:0]   cnt_n;
   logic [FRAME_W-1:0] held0_n, held1_n, d;
   fold_type           acc_n, acc_f;
   logic [FRAME_W-1:0] crc_c, lrc_c;
   logic [CNT_W-1:0]   frames;
   logic               tapemark;

   always_comb begin
      d = nine_track ? frame : (frame & MASK7);
      cnt_n = count_ff;
      held0_n = held0_ff;
      held1_n = held1_ff;
      acc_n = acc_ff;
      first_in = first_ff;
      if (count_ff < CNT_W'(MAX_FRAMES)) begin
         if (count_ff < CNT_W'(3)) begin
            first_in[count_ff[1:0]] = d;
         end
         if (count_ff >= CNT_W'(2)) begin
            acc_n = fold_frame(acc_ff, held0_ff, parity_exp);
         end
         held0_n = held1_ff;
         held1_n = d;
         cnt_n = count_ff + CNT_W'(1);
      end

      tapemark = (nine_track && cnt_n == CNT_W'(3) && first_in[0] == TM9_MARK &&
                  first_in[1] == '0 && first_in[2] == TM9_MARK) ||
                 (!nine_track && cnt_n == CNT_W'(2) && first_in[0] == TM7_MARK &&
                  first_in[1] == TM7_MARK);

      // 7-track: crc position frame is data
      acc_f = nine_track ? acc_n : fold_frame(acc_n, held0_n, parity_exp);
      crc_c = acc_f.crc ^ CRC_XOROUT;
      lrc_c = nine_track ? (acc_f.lrc ^ crc_c) : acc_f.lrc;
      frames = cnt_n;

      result = '0;
      if (cnt_n <= CNT_W'(1)) begin
         result.block_kind = KIND_NOISE;
      end else if (tapemark) begin
         result.block_kind = KIND_TAPEMARK;
      end else begin
         result.block_kind = KIND_DATA;
         if (cnt_n > CNT_W'(2)) begin
            result.crc_read = held0_n;
            result.lrc_read = held1_n;
            result.parity_errors = acc_f.perr;
            result.crc_bad = nine_track && (crc_c != held0_n);
            result.lrc_bad = (lrc_c != held1_n);
            frames = cnt_n - (nine_track ? CNT_W'(2) : CNT_W'(1));
         end
      end
      result.data_frames = OUT_CNT_W'(frames);
      result.error_total = result.parity_errors + OUT_CNT_W'(result.crc_bad)
                           + OUT_CNT_W'(result.lrc_bad);

      if (last_frame) begin
         count_in = '0;
         held0_in = '0;
         held1_in = '0;
         acc_in = '0;
         first_in[0] = '0;
         first_in[1] = '0;
         first_in[2] = '0;
      end else begin
         count_in = cnt_n;
         held0_in = held0_n;
         held1_in = held1_n;
         acc_in = acc_n;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         held0_ff <= '0;
         held1_ff <= '0;
         acc_ff <= '0;
         first_ff[0] <= '0;
         first_ff[1] <= '0;
         first_ff[2] <= '0;
      end else if (step) begin
         count_ff <= count_in;
         held0_ff <= held0_in;
         held1_ff <= held1_in;
         acc_ff <= acc_in;
         first_ff <= first_in;
      end
   end

endmodule

// ===== sv/nrzi_tape_block_check.sv =====
// top level of the nrzi tape block check: channels, config registers, item pipeline
// depends on ntbc_pkg, the three channel interfaces, ntbc_core and the assert macros
//
// usage:
//   req_ch carries one track-parallel frame per item, last_frame set on the
//   final frame of a tape block. rsp_ch carries one report per block, sent
//   for the item that has last_frame set; other items give no report.
//   csr_ch writes nine_track_mode (index 0) and parity_expected (index 1);
//   writes are taken at any time, other indexes are ignored. write only
//   while no block report is pending.
// timing:
//   one item per cycle while no end-of-block item waits on a held report;
//   data frames pass the input register, held1 and held0 before the fold
//   into the crc, lrc and parity count; the report is registered for rsp_ch.
// stall:
//   the report waits in the output register until taken. frames keep being
//   accepted meanwhile; only a second end-of-block item waits in the input
//   register while the report is still held.
// reset:
//   synchronous, clears the block state and selects 9-track odd parity.
`include "nrzi_tape_block_check_assert.svh"

module nrzi_tape_block_check
   import ntbc_pkg::*;
(
   input logic        clock,
   input logic        reset,
   ntbc_req_if.sink   req_ch,
   ntbc_rsp_if.source rsp_ch,
   ntbc_csr_if.sink   csr_ch
);

   logic               nine_ff, nine_in, pexp_ff, pexp_in;
   logic               s1_valid_ff, s1_valid_in;
   logic [FRAME_W-1:0] s1_frame_ff;
   logic               s1_last_ff;
   logic               out_valid_ff, out_valid_in;
   result_type         out_ff, core_res;
   logic               out_free, s1_adv, req_take;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      nine_in = nine_ff;
      pexp_in = pexp_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_NINE_TRACK: nine_in = csr_ch.data;
            CSR_PARITY:     pexp_in = csr_ch.data;
            default: ;
         endcase
      end
   end

   assign out_free = !out_valid_ff || rsp_ch.ready;
   assign s1_adv = s1_valid_ff && (!s1_last_ff || out_free);
   assign req_ch.ready = !s1_valid_ff || s1_adv;
   assign req_take = req_ch.valid && req_ch.ready;
   assign s1_valid_in = req_take || (s1_valid_ff && !s1_adv);
   assign out_valid_in = (s1_adv && s1_last_ff) || (out_valid_ff && !rsp_ch.ready);

   ntbc_core u_core (
      .clock      (clock),
      .reset      (reset),
      .step       (s1_adv),
      .frame      (s1_frame_ff),
      .last_frame (s1_last_ff),
      .nine_track (nine_ff),
      .parity_exp (pexp_ff),
      .result     (core_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         nine_ff <= 1'b1;
         pexp_ff <= 1'b1;
         s1_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         nine_ff <= nine_in;
         pexp_ff <= pexp_in;
         s1_valid_ff <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_frame_ff <= req_ch.frame;
         s1_last_ff <= req_ch.last_frame;
      end
      if (s1_adv && s1_last_ff) begin
         out_ff <= core_res;
      end
   end

   assign rsp_ch.valid = out_valid_ff;
   assign rsp_ch.block_kind = out_ff.block_kind;
   assign rsp_ch.data_frames = out_ff.data_frames;
   assign rsp_ch.parity_errors = out_ff.parity_errors;
   assign rsp_ch.crc_bad = out_ff.crc_bad;
   assign rsp_ch.lrc_bad = out_ff.lrc_bad;
   assign rsp_ch.error_total = out_ff.error_total;
   assign rsp_ch.crc_read = out_ff.crc_read;
   assign rsp_ch.lrc_read = out_ff.lrc_read;

   `NTBC_ASSERT_NOW(a_stall_only_on_full, s1_valid_ff && !s1_adv,
      s1_last_ff && out_valid_ff && !rsp_ch.ready, "input stage stalled without cause")
   `NTBC_ASSERT_NOW(a_report_source, $rose(out_valid_ff),
      $past(s1_adv && s1_last_ff), "report without end-of-block item")
   `NTBC_ASSERT_NOW(a_no_checks_off_data, out_valid_ff && out_ff.block_kind != KIND_DATA,
      out_ff.error_total == '0 && !out_ff.crc_bad && !out_ff.lrc_bad,
      "check flags set on non-data block")

endmodule
